>>> hw/rtl/rca_pkg.sv
package rca_pkg;

  // Request codes carried in the input tuser field.
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_SYNC      = 3'd1;
  localparam logic [2:0] REQ_ALARM_SET = 3'd2;
  localparam logic [2:0] REQ_DISARM    = 3'd3;
  localparam logic [2:0] REQ_ACK       = 3'd4;

  localparam int unsigned REQ_W       = 3;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // Date and time, year in the top bits so that a plain unsigned compare of
  // the packed value orders two times year first, second last.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rtc_time_t;

  // One request as held in the input register.
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    rtc_time_t        tm;
  } rtc_item_t;

endpackage

>>> hw/rtl/rtc_calendar_alarm.sv
// Real-time clock and calendar with a one-shot alarm.
//
// Requests arrive on the s_axis channel: tuser holds the request kind (tick
// one second, sync time, set and arm alarm, disarm, acknowledge) and tdata
// the date and time used by sync and alarm set. Every request produces
// exactly one result transfer on m_axis carrying the date and time after the
// request together with the synced, armed, ringing and fired flags.
//
// A request is taken into an input register, and from there the
// calendar carry chain, the leap-year test and the alarm compare update the
// state and the result register once the result register is free. One request
// is taken every cycle while m_axis_tready is high, limited by the single
// update of the state registers per request.
//
// Reset clears the time and the synced, armed and ringing flags and empties
// both registers. When the receiver holds m_axis_tready low the result is
// held, one further request is taken into the input register, and then
// s_axis_tready drops until the result transfer completes.
module rtc_calendar_alarm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // year, month, day, hour, minute, second, zero fill
  input  logic [rca_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [rca_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // now_year, now_month, now_day, now_hour, now_minute, now_second,
  // time_valid, alarm_armed, alarm_active, alarm_fired, zero fill
  output logic [rca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  rca_pkg::rtc_item_t item;
  rca_pkg::rtc_item_t item_in;
  logic               in_full;
  logic               eng_ready;

  // Unpack the input transfer into a request.
  always_comb begin
    item_in.req_type  = s_axis_tuser;
    item_in.tm.year   = s_axis_tdata[15:0];
    item_in.tm.month  = s_axis_tdata[19:16];
    item_in.tm.day    = s_axis_tdata[24:20];
    item_in.tm.hour   = s_axis_tdata[29:25];
    item_in.tm.minute = s_axis_tdata[35:30];
    item_in.tm.second = s_axis_tdata[41:36];
  end

  // The input register refills in the same cycle the engine takes it.
  assign s_axis_tready = !in_full || eng_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (eng_ready) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_in;
    end
  end

  rca_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (in_full),
    .item          (item),
    .item_ready    (eng_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/rca_calendar.sv
module rca_calendar (
  input  rca_pkg::rtc_time_t cur,
  output rca_pkg::rtc_time_t nxt
);

  localparam logic [6:0] SECS_PER_MIN    = 7'd60;
  localparam logic [6:0] MINS_PER_HOUR   = 7'd60;
  localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
  localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
  // Reciprocal of 25 scaled by 2^21; a multiple of 25 leaves the bits
  // 20 down to 16 of the product clear, any other year does not.
  localparam logic [16:0] RECIP_25 = 17'd83887;

  // Days of a month; a month outside one to twelve counts as 31 days.
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                     d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

  logic [20:0] year_scaled;
  logic        div25;
  logic        leap;
  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic        sec_carry;
  logic        min_carry;
  logic        hour_carry;
  logic        day_carry;
  logic        month_carry;

  // Gregorian leap rule: divisible by 4, and not by 100 unless by 400.
  // With 100 = 4 * 25 and 400 = 16 * 25 only a test for 25 is needed.
  assign year_scaled = {5'b0, cur.year} * {4'b0, RECIP_25};
  assign div25       = (year_scaled[20:16] == 5'd0);
  assign leap        = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));

  // Full-width increment; h:m:s wrap by subtraction, day/month to 1.
  assign sec_inc   = {1'b0, cur.second} + 7'd1;
  assign sec_carry = (sec_inc >= SECS_PER_MIN);

  assign min_inc   = {1'b0, cur.minute} + 7'd1;
  assign min_carry = sec_carry && (min_inc >= MINS_PER_HOUR);

  assign hour_inc   = {1'b0, cur.hour} + 6'd1;
  assign hour_carry = min_carry && (hour_inc >= HOURS_PER_DAY);

  assign day_inc   = {1'b0, cur.day} + 6'd1;
  assign day_carry = hour_carry && (day_inc > {1'b0, days_in(cur.month, leap)});

  assign month_inc   = {1'b0, cur.month} + 5'd1;
  assign month_carry = day_carry && (month_inc > MONTHS_PER_YEAR);

  // Select the advanced fields along the carry chain.
  always_comb begin
    nxt = cur;
    if (sec_carry) begin
      nxt.second = 6'(sec_inc - SECS_PER_MIN);
    end else begin
      nxt.second = sec_inc[5:0];
    end
    if (sec_carry) begin
      nxt.minute = min_carry ? 6'(min_inc - MINS_PER_HOUR) : min_inc[5:0];
    end
    if (min_carry) begin
      nxt.hour = hour_carry ? 5'(hour_inc - HOURS_PER_DAY) : hour_inc[4:0];
    end
    if (hour_carry) begin
      nxt.day = day_carry ? 5'd1 : day_inc[4:0];
    end
    if (day_carry) begin
      nxt.month = month_carry ? 4'd1 : month_inc[3:0];
    end
    if (month_carry) begin
      nxt.year = cur.year + 16'd1;
    end
  end

endmodule

>>> hw/rtl/rca_engine.sv
module rca_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  rca_pkg::rtc_item_t                   item,
  output logic                                 item_ready,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // now_year, now_month, now_day, now_hour, now_minute, now_second,
  // time_valid, alarm_armed, alarm_active, alarm_fired, zero fill
  output logic [rca_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  rca_pkg::rtc_time_t now_time;
  rca_pkg::rtc_time_t now_time_next;
  rca_pkg::rtc_time_t alarm_time;
  rca_pkg::rtc_time_t alarm_time_next;
  rca_pkg::rtc_time_t ticked;
  logic               synced;
  logic               synced_next;
  logic               armed;
  logic               armed_next;
  logic               ringing;
  logic               ringing_next;
  logic               fired;
  logic               fired_q;
  logic               advance;

  // The state only moves when the result of the request can be registered,
  // so the state registers always equal the result being offered.
  assign item_ready = !m_axis_tvalid || m_axis_tready;
  assign advance    = item_valid && item_ready;

  rca_calendar u_calendar (
    .cur (now_time),
    .nxt (ticked)
  );

  // Request decode and alarm check.
  always_comb begin
    now_time_next   = now_time;
    alarm_time_next = alarm_time;
    synced_next     = synced;
    armed_next      = armed;
    ringing_next    = ringing;
    fired           = 1'b0;
    unique case (item.req_type)
      rca_pkg::REQ_TICK: begin
        if (synced) begin
          now_time_next = ticked;
          if (armed && !ringing && (ticked >= alarm_time)) begin
            armed_next   = 1'b0;
            ringing_next = 1'b1;
            fired        = 1'b1;
          end
        end
      end
      rca_pkg::REQ_SYNC: begin
        now_time_next = item.tm;
        synced_next   = 1'b1;
      end
      rca_pkg::REQ_ALARM_SET: begin
        alarm_time_next = item.tm;
        armed_next      = 1'b1;
      end
      rca_pkg::REQ_DISARM: begin
        armed_next = 1'b0;
      end
      rca_pkg::REQ_ACK: begin
        ringing_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Clock, status and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time      <= '0;
      synced        <= 1'b0;
      armed         <= 1'b0;
      ringing       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        now_time      <= now_time_next;
        synced        <= synced_next;
        armed         <= armed_next;
        ringing       <= ringing_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // The alarm time is only compared once it has been written.
  always_ff @(posedge clk) begin
    if (advance) begin
      alarm_time <= alarm_time_next;
      fired_q    <= fired;
    end
  end

  assign m_axis_tdata = {2'b00, fired_q, ringing, armed, synced,
                         now_time.second, now_time.minute, now_time.hour,
                         now_time.day, now_time.month, now_time.year};

  a_fire_rings: assert property (@(posedge clk) disable iff (rst)
    (advance && fired) |=> (ringing && !armed))
    else $error("alarm fired without ringing and disarming");

  a_fire_shown: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && fired_q) |-> (ringing && !armed && synced))
    else $error("fired result disagrees with alarm status");

  a_fire_on_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && fired) |-> ((item.req_type == rca_pkg::REQ_TICK) && synced))
    else $error("alarm fired on a request other than a synced tick");

  a_unsynced_zero: assert property (@(posedge clk) disable iff (rst)
    !synced |-> (now_time == '0))
    else $error("time moved before the first sync");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(now_time) && $stable(armed) && $stable(ringing)))
    else $error("state changed without a request transfer");

endmodule
